>>> rtl/cht_pkg.sv
`timescale 1ns / 1ps

package cht_pkg;

   // Field widths
   localparam int KEY_W   = 64;
   localparam int COUNT_W = 32;
   localparam int EPOCH_W = 16;
   localparam int CFG_W   = 4;
   localparam int OP_W    = 2;
   localparam int HALF_W  = 32;

   // Fixed odd hash multiplier, split in halves for the 32x32 multiplier
   localparam logic [KEY_W-1:0]  HASH_MUL    = 64'd12345678911234567891;
   localparam logic [HALF_W-1:0] HASH_MUL_LO = HASH_MUL[31:0];
   localparam logic [HALF_W-1:0] HASH_MUL_HI = HASH_MUL[63:32];

   localparam logic [CFG_W-1:0]   CFG_RESET = 4'd10;
   localparam logic [EPOCH_W-1:0] EPOCH_ONE = 16'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = 16'hFFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   // Partial product steps of the hash multiply
   typedef logic [1:0] mul_step_type;
   localparam mul_step_type MUL_LO_LO = 2'd0;
   localparam mul_step_type MUL_LO_HI = 2'd1;
   localparam mul_step_type MUL_HI_LO = 2'd2;

   // Result selection
   typedef logic [2:0] res_sel_type;
   localparam res_sel_type RES_ZERO  = 3'd0;
   localparam res_sel_type RES_ONE   = 3'd1;
   localparam res_sel_type RES_COUNT = 3'd2;
   localparam res_sel_type RES_BUMP  = 3'd3;
   localparam res_sel_type RES_OVF   = 3'd4;

   // Controller to datapath
   typedef struct packed {
      logic         load_req;
      logic         mul_en;
      mul_step_type mul_step;
      logic         hash_en;
      logic         probe_next;
      logic         wr_new;
      logic         wr_bump;
      logic         res_load;
      res_sel_type  res_sel;
      logic         epoch_adv;
      logic         sweep_en;
      logic         out_load;
   } cht_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic slot_empty;
      logic slot_hit;
      logic slot_last;
      logic epoch_last;
      logic sweep_last;
      logic out_free;
   } cht_stat_type;

endpackage

>>> rtl/cht_req_if.sv
`timescale 1ns / 1ps

interface cht_req_if;
   import cht_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   req_type;
   logic [KEY_W-1:0]  key;

   modport source (output valid, output req_type, output key, input ready);
   modport sink   (input valid, input req_type, input key, output ready);
endinterface

>>> rtl/cht_rsp_if.sv
`timescale 1ns / 1ps

interface cht_rsp_if;
   import cht_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] count;
   logic               status;

   modport source (output valid, output count, output status, input ready);
   modport sink   (input valid, input count, input status, output ready);
endinterface

>>> rtl/cht_ctrl.sv
`timescale 1ns / 1ps

module cht_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [cht_pkg::OP_W-1:0] req_type,
   output logic                    req_ready,
   input  cht_pkg::cht_stat_type   stat,
   output cht_pkg::cht_cmd_type    cmd
);
   import cht_pkg::*;

   localparam logic [2:0] ST_SWEEP = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL0  = 3'd2;
   localparam logic [2:0] ST_MUL1  = 3'd3;
   localparam logic [2:0] ST_MUL2  = 3'd4;
   localparam logic [2:0] ST_HASH  = 3'd5;
   localparam logic [2:0] ST_PROBE = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]      state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic            sweep_pend_ff, sweep_pend_in;
   logic            accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      sweep_pend_in = sweep_pend_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_en = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               op_in        = req_type;
               unique case (req_type) inside
                  OP_INSERT, OP_FIND: begin
                     state_in = ST_MUL0;
                  end
                  OP_CLEAR: begin
                     cmd.epoch_adv = 1'b1;
                     cmd.res_load  = 1'b1;
                     cmd.res_sel   = RES_ZERO;
                     sweep_pend_in = stat.epoch_last;
                     state_in      = ST_DONE;
                  end
                  default: begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = RES_ZERO;
                     state_in     = ST_DONE;
                  end
               endcase
            end
         end
         ST_MUL0: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MUL_LO_LO;
            state_in     = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MUL_LO_HI;
            state_in     = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MUL_HI_LO;
            state_in     = ST_HASH;
         end
         ST_HASH: begin
            cmd.hash_en = 1'b1;
            state_in    = ST_PROBE;
         end
         ST_PROBE: begin
            // one slot per cycle until hit, empty slot or end of table
            if (stat.slot_empty) begin
               cmd.res_load = 1'b1;
               if (op_ff == OP_INSERT) begin
                  cmd.wr_new  = 1'b1;
                  cmd.res_sel = RES_ONE;
               end else begin
                  cmd.res_sel = RES_ZERO;
               end
               state_in = ST_DONE;
            end else if (stat.slot_hit) begin
               cmd.res_load = 1'b1;
               if (op_ff == OP_INSERT) begin
                  cmd.wr_bump = 1'b1;
                  cmd.res_sel = RES_BUMP;
               end else begin
                  cmd.res_sel = RES_COUNT;
               end
               state_in = ST_DONE;
            end else if (stat.slot_last) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_OVF;
               state_in     = ST_DONE;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.out_load  = 1'b1;
               sweep_pend_in = 1'b0;
               state_in      = sweep_pend_ff ? ST_SWEEP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         op_ff         <= OP_NONE;
         sweep_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         sweep_pend_ff <= sweep_pend_in;
      end
   end

endmodule

>>> rtl/cht_datapath.sv
`timescale 1ns / 1ps

module cht_datapath #(
   parameter int TABLE_BITS  = 10,
   parameter int PROBE_SLACK = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [cht_pkg::KEY_W-1:0]   req_key,
   input  logic                        csr_we,
   input  logic [cht_pkg::CFG_W-1:0]   csr_wdata,
   input  cht_pkg::cht_cmd_type        cmd,
   output cht_pkg::cht_stat_type       stat,
   cht_rsp_if.source                   rsp
);
   import cht_pkg::*;

   localparam int SLOT_COUNT = (1 << TABLE_BITS) + PROBE_SLACK;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int SHIFT_W    = $clog2(TABLE_BITS);

   // Configuration and request registers
   logic [CFG_W-1:0]   cfg_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [EPOCH_W-1:0] epoch_ff;

   // Hash multiply
   logic [HALF_W-1:0]   mul_a, mul_b;
   logic [2*HALF_W-1:0] prod_ff;
   logic [HALF_W-1:0]   hi_ff;
   logic [HALF_W-1:0]   hash_hi;
   logic [SHIFT_W-1:0]  shift_amt;
   logic [TABLE_BITS-1:0] home_idx;
   int                  used_bits;

   // Probe and sweep addresses
   logic [SLOT_W-1:0] probe_ff, probe_in;
   logic [SLOT_W-1:0] sweep_ff;

   // Slot memories
   logic [KEY_W-1:0]   key_mem   [SLOT_COUNT];
   logic [COUNT_W-1:0] count_mem [SLOT_COUNT];
   logic [EPOCH_W-1:0] epoch_mem [SLOT_COUNT];
   logic [KEY_W-1:0]   rd_key_ff;
   logic [COUNT_W-1:0] rd_count_ff;
   logic [EPOCH_W-1:0] rd_epoch_ff;
   logic [COUNT_W-1:0] bumped;
   logic               epoch_we;
   logic [SLOT_W-1:0]  epoch_waddr;
   logic [EPOCH_W-1:0] epoch_wdata;

   // Result and output registers
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               res_status_ff, res_status_in;
   logic [COUNT_W-1:0] out_count_ff;
   logic               out_status_ff;
   logic               out_valid_ff, out_valid_in;

   // Configuration, key and epoch
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         epoch_ff <= EPOCH_ONE;
      end else begin
         if (csr_we) begin
            cfg_ff <= csr_wdata;
         end
         if (cmd.epoch_adv) begin
            epoch_ff <= (epoch_ff == EPOCH_MAX) ? EPOCH_ONE : epoch_ff + EPOCH_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         key_ff <= req_key;
      end
   end

   // Shared 32x32 multiplier; only the upper product word feeds the hash
   always_comb begin
      mul_a = (cmd.mul_step == MUL_HI_LO) ? key_ff[63:32] : key_ff[31:0];
      mul_b = (cmd.mul_step == MUL_LO_HI) ? HASH_MUL_HI : HASH_MUL_LO;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= (2*HALF_W)'(mul_a) * (2*HALF_W)'(mul_b);
         case (cmd.mul_step)
            MUL_LO_HI: hi_ff <= prod_ff[63:32];
            MUL_HI_LO: hi_ff <= hi_ff + prod_ff[31:0];
            default:   hi_ff <= hi_ff;
         endcase
      end
   end

   // Home slot: top used_bits bits of the product
   always_comb begin
      used_bits = int'(cfg_ff);
      if (used_bits < 1) begin
         used_bits = 1;
      end
      if (used_bits > TABLE_BITS) begin
         used_bits = TABLE_BITS;
      end
      shift_amt = SHIFT_W'(TABLE_BITS - used_bits);
      hash_hi   = hi_ff + prod_ff[31:0];
      home_idx  = hash_hi[HALF_W-1 -: TABLE_BITS] >> shift_amt;
   end

   // Probe address; read address is the next probe so data lands in time
   always_comb begin
      probe_in = probe_ff;
      if (cmd.hash_en) begin
         probe_in = SLOT_W'(home_idx);
      end else if (cmd.probe_next) begin
         probe_in = probe_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
         sweep_ff <= '0;
      end else begin
         probe_ff <= probe_in;
         if (cmd.sweep_en) begin
            sweep_ff <= stat.sweep_last ? '0 : sweep_ff + 1'b1;
         end
      end
   end

   // Slot memories, one write and one registered read port each
   assign bumped = (rd_count_ff == COUNT_MAX) ? COUNT_MAX : rd_count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.wr_new) begin
         key_mem[probe_ff] <= key_ff;
      end
      rd_key_ff <= key_mem[probe_in];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_new) begin
         count_mem[probe_ff] <= COUNT_W'(1);
      end else if (cmd.wr_bump) begin
         count_mem[probe_ff] <= bumped;
      end
      rd_count_ff <= count_mem[probe_in];
   end

   always_comb begin
      epoch_we    = cmd.sweep_en || cmd.wr_new;
      epoch_waddr = cmd.sweep_en ? sweep_ff : probe_ff;
      epoch_wdata = cmd.sweep_en ? '0 : epoch_ff;
   end

   always_ff @(posedge clock) begin
      if (epoch_we) begin
         epoch_mem[epoch_waddr] <= epoch_wdata;
      end
      rd_epoch_ff <= epoch_mem[probe_in];
   end

   // Status toward the controller
   always_comb begin
      stat.slot_empty = (rd_epoch_ff != epoch_ff);
      stat.slot_hit   = (rd_epoch_ff == epoch_ff) && (rd_key_ff == key_ff);
      stat.slot_last  = (probe_ff == SLOT_W'(SLOT_COUNT - 1));
      stat.epoch_last = (epoch_ff == EPOCH_MAX);
      stat.sweep_last = (sweep_ff == SLOT_W'(SLOT_COUNT - 1));
      stat.out_free   = !out_valid_ff || rsp.ready;
   end

   // Result selection
   always_comb begin
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      if (cmd.res_load) begin
         res_status_in = 1'b0;
         case (cmd.res_sel)
            RES_ONE:   res_count_in = COUNT_W'(1);
            RES_COUNT: res_count_in = rd_count_ff;
            RES_BUMP:  res_count_in = bumped;
            RES_OVF: begin
               res_count_in  = '0;
               res_status_in = 1'b1;
            end
            default:   res_count_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      if (cmd.out_load) begin
         out_count_ff  <= res_count_ff;
         out_status_ff <= res_status_ff;
      end
   end

   // Output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.count  = out_count_ff;
   assign rsp.status = out_status_ff;

endmodule

>>> rtl/counting_hash_table_top.sv
`timescale 1ns / 1ps

// Counting hash table: counts occurrences of 64-bit keys in an open-addressing
// table of 2**TABLE_BITS + PROBE_SLACK slots with linear probing. The home slot
// is the top table_bits bits (csr register, clamped to 1..TABLE_BITS) of
// key * 12345678911234567891 mod 2**64. Insert and find take three passes of
// one shared 32x32 multiplier, a hash step, then one slot per cycle through
// the slot memories (one write and one read port each). Clear and the unused
// opcode go straight to the result. Clear bumps an epoch tag; when the tag
// wraps, and after reset, a sweep of all 2**TABLE_BITS + PROBE_SLACK slots
// (1152 by default) zeroes the slot tags and no request is taken meanwhile.
// A probe that reaches the last slot with no hit and no empty slot gives
// status 1 and count 0 and changes nothing. Counts saturate at 2**32 - 1.
module counting_hash_table_top #(
   parameter int TABLE_BITS  = 10,
   parameter int PROBE_SLACK = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   cht_req_if.sink                   req,
   cht_rsp_if.source                 rsp,
   input  logic                      csr_we,
   input  logic [cht_pkg::CFG_W-1:0] csr_wdata
);
   import cht_pkg::*;

   cht_cmd_type  cmd;
   cht_stat_type stat;
   logic         req_ready;

   assign req.ready = req_ready;

   // Sequencer
   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_type  (req.req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hash, slot memories and result registers
   cht_datapath #(
      .TABLE_BITS  (TABLE_BITS),
      .PROBE_SLACK (PROBE_SLACK)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_key   (req.key),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp       (rsp)
   );

endmodule
